// File: rtl/core/rrtg_pkg.sv
// ----------------------------------------------------------------------------
// Round robin token gate: shared definitions
// Field widths, event codes, register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rrtg_pkg;

	localparam int OP_W   = 3;
	localparam int MBR_W  = 5;
	localparam int WORD_W = 32;

	localparam int DEF_RING_SLOTS = 32;
	localparam int DEF_MEMBER_IDS = 32;

	localparam logic [WORD_W-1:0] QUANTUM_RST = 32'h0001_0000;

	// Event codes.
	localparam logic [OP_W-1:0] OP_REGISTER    = 3'd0;
	localparam logic [OP_W-1:0] OP_UNREGISTER  = 3'd1;
	localparam logic [OP_W-1:0] OP_TICK        = 3'd2;
	localparam logic [OP_W-1:0] OP_BLOCK_BEGIN = 3'd3;
	localparam logic [OP_W-1:0] OP_BLOCK_END   = 3'd4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM     = 1'b1;

	typedef struct packed {
		logic load;
		logic tick_zero;
		logic tick_inc;
		logic scan_find;
		logic scan_free;
		logic scan_next;
		logic install;
		logic set_full;
		logic set_run;
		logic clr_run;
		logic clr_active;
		logic take_if_free;
		logic take_self;
		logic rel_tok;
		logic hand_over;
		logic count_pass;
		logic wait_rule;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic            ignore;
		logic [OP_W-1:0] op;
		logic            tick_below;
		logic            scan_busy;
		logic            scan_done;
		logic            slot_hit;
		logic            nxt_hit;
		logic            slots_avail;
		logic            is_holder;
		logic            out_free;
	} dp_sts_t;

endpackage

// File: rtl/core/rrtg_ctrl.sv
// ----------------------------------------------------------------------------
// Round robin token gate: controller
// Sequences one event at a time through decode, tick update, slot scans and
// token actions, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module rrtg_ctrl import rrtg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DEC  = 8'b0000_0010,
		S_TCHK = 8'b0000_0100,
		S_FIND = 8'b0000_1000,
		S_ACT  = 8'b0001_0000,
		S_NEXT = 8'b0010_0000,
		S_PASS = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.ignore) begin
					state_d = S_FIN;
				end else begin
					unique case (sts.op)
						OP_REGISTER: begin
							cmd.tick_zero = 1'b1;
							cmd.scan_free = 1'b1;
							state_d       = S_FIND;
						end
						OP_TICK: begin
							state_d = S_TCHK;
						end
						OP_UNREGISTER, OP_BLOCK_BEGIN, OP_BLOCK_END: begin
							cmd.scan_find = 1'b1;
							state_d       = S_FIND;
						end
						default: begin
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_TCHK: begin
				if (sts.tick_below) begin
					cmd.tick_inc = 1'b1;
					state_d      = S_FIN;
				end else begin
					cmd.tick_zero = 1'b1;
					cmd.scan_find = 1'b1;
					state_d       = S_FIND;
				end
			end
			S_FIND: begin
				if (sts.scan_done) begin
					state_d = S_ACT;
				end
			end
			S_ACT: begin
				state_d = S_FIN;
				unique case (sts.op)
					OP_REGISTER: begin
						if (sts.slot_hit || sts.slots_avail) begin
							cmd.install      = 1'b1;
							cmd.take_if_free = 1'b1;
							cmd.wait_rule    = 1'b1;
						end else begin
							cmd.set_full = 1'b1;
						end
					end
					OP_UNREGISTER: begin
						if (sts.slot_hit) begin
							if (sts.is_holder) begin
								cmd.scan_next = 1'b1;
								state_d       = S_NEXT;
							end else begin
								cmd.clr_active = 1'b1;
							end
						end
					end
					OP_TICK: begin
						cmd.set_run   = 1'b1;
						cmd.wait_rule = 1'b1;
						if (sts.is_holder && sts.slot_hit) begin
							cmd.scan_next = 1'b1;
							state_d       = S_NEXT;
						end else begin
							cmd.take_self = 1'b1;
						end
					end
					OP_BLOCK_BEGIN: begin
						cmd.clr_run = 1'b1;
						if (sts.is_holder) begin
							if (sts.slot_hit) begin
								cmd.scan_next = 1'b1;
								state_d       = S_NEXT;
							end else begin
								cmd.rel_tok = 1'b1;
							end
						end
					end
					default: begin
						cmd.set_run      = 1'b1;
						cmd.take_if_free = 1'b1;
						cmd.wait_rule    = 1'b1;
					end
				endcase
			end
			S_NEXT: begin
				if (sts.scan_done) begin
					state_d = S_PASS;
				end
			end
			S_PASS: begin
				state_d = S_FIN;
				unique case (sts.op)
					OP_UNREGISTER: begin
						// Handing over on unregister does not count as a pass.
						cmd.clr_active = 1'b1;
						if (sts.nxt_hit) begin
							cmd.hand_over = 1'b1;
						end else begin
							cmd.rel_tok = 1'b1;
						end
					end
					OP_TICK: begin
						if (sts.nxt_hit) begin
							cmd.hand_over  = 1'b1;
							cmd.count_pass = 1'b1;
						end
					end
					default: begin
						if (sts.nxt_hit) begin
							cmd.hand_over  = 1'b1;
							cmd.count_pass = 1'b1;
						end else begin
							cmd.rel_tok = 1'b1;
						end
					end
				endcase
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/rrtg_datapath.sv
// ----------------------------------------------------------------------------
// Round robin token gate: datapath
// Holds the configuration, the ring slots, the per-member tick counters,
// the token holder and the result register, and runs the slot scanner.
// ----------------------------------------------------------------------------
module rrtg_datapath import rrtg_pkg::*; #(
	parameter int RING_SLOTS = DEF_RING_SLOTS,
	parameter int MEMBER_IDS = DEF_MEMBER_IDS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic [OP_W-1:0]      op,
	input  logic [MBR_W-1:0]     member_id,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 holder_valid,
	output logic [MBR_W-1:0]     holder_id,
	output logic                 must_wait,
	output logic                 ring_full,
	output logic                 token_passed,
	output logic [WORD_W-1:0]    pass_count,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts
);

	localparam int SW = $clog2(RING_SLOTS);
	localparam int CW = $clog2(RING_SLOTS + 1);
	localparam int TW = $clog2(MEMBER_IDS);
	localparam int MX = MBR_W + 2;

	// Configuration.
	logic              gate_q;
	logic [WORD_W-1:0] quantum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q    <= 1'b0;
			quantum_q <= QUANTUM_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_GATE_ENABLE) begin
				gate_q <= cfg_data[0];
			end
			if (cfg_index == CFG_QUANTUM) begin
				quantum_q <= cfg_data;
			end
		end
	end

	// Event in hand.
	logic [OP_W-1:0]  op_q;
	logic [MBR_W-1:0] m_q;
	logic [MX-1:0]    m_wide;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			m_q  <= member_id;
		end
	end

	assign m_wide = {2'b00, m_q};

	// Per-member tick counters; an entry never written reads as zero.
	logic [WORD_W-1:0]     tick_mem [MEMBER_IDS];
	logic [MEMBER_IDS-1:0] tick_vld_q;
	logic [WORD_W-1:0]     tick_rd_q;
	logic                  tick_vld_rd_q;
	logic [TW-1:0]         tick_addr;
	logic [WORD_W-1:0]     tick_cnt;
	logic [WORD_W-1:0]     tick_next;
	logic                  tick_wr;

	assign tick_addr = m_wide[TW-1:0];
	assign tick_cnt  = tick_vld_rd_q ? tick_rd_q : '0;
	assign tick_next = tick_cnt + 32'd1;
	assign tick_wr   = cmd.tick_zero | cmd.tick_inc;

	always_ff @(posedge clk) begin
		if (tick_wr) begin
			tick_mem[tick_addr] <= cmd.tick_inc ? tick_next : '0;
		end
		tick_rd_q <= tick_mem[tick_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_vld_q    <= '0;
			tick_vld_rd_q <= 1'b0;
		end else begin
			if (tick_wr) begin
				tick_vld_q[tick_addr] <= 1'b1;
			end
			tick_vld_rd_q <= tick_vld_q[tick_addr];
		end
	end

	// Ring slots.
	logic [MBR_W-1:0]      slot_mem [RING_SLOTS];
	logic [RING_SLOTS-1:0] slot_act_q;
	logic [RING_SLOTS-1:0] slot_rdy_q;
	logic [CW-1:0]         used_q;
	logic                  slot_hit_q;
	logic [SW-1:0]         slot_idx_q;
	logic [SW-1:0]         ins_idx;

	assign ins_idx = slot_hit_q ? slot_idx_q : used_q[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_act_q <= '0;
			slot_rdy_q <= '0;
			used_q     <= '0;
		end else begin
			if (cmd.install) begin
				slot_act_q[ins_idx] <= 1'b1;
				slot_rdy_q[ins_idx] <= 1'b1;
				if (!slot_hit_q) begin
					used_q <= used_q + CW'(1);
				end
			end
			if (cmd.set_run && slot_hit_q) begin
				slot_rdy_q[slot_idx_q] <= 1'b1;
			end
			if (cmd.clr_run && slot_hit_q) begin
				slot_rdy_q[slot_idx_q] <= 1'b0;
			end
			if (cmd.clr_active) begin
				slot_act_q[slot_idx_q] <= 1'b0;
			end
		end
	end

	// Slot scanner: one probe a cycle, compare in the cycle after the memory read.
	logic             busy_q;
	logic             mode_free_q;
	logic             mode_next_q;
	logic [SW-1:0]    addr_q;
	logic [CW-1:0]    left_q;
	logic             vld_s1;
	logic [SW-1:0]    ptr_s1;
	logic [MBR_W-1:0] mbr_s1;
	logic             nxt_hit_q;
	logic [MBR_W-1:0] nxt_mbr_q;
	logic [CW-1:0]    addr_inc;
	logic [SW-1:0]    addr_wrap;
	logic [CW-1:0]    idx_inc;
	logic [SW-1:0]    next_start;
	logic             scan_start;
	logic             probe_ok;
	logic             hit_s1;
	logic             scan_done;

	assign addr_inc   = CW'(addr_q) + CW'(1);
	assign addr_wrap  = (addr_inc == used_q) ? '0 : addr_inc[SW-1:0];
	assign idx_inc    = CW'(slot_idx_q) + CW'(1);
	assign next_start = (idx_inc == used_q) ? '0 : idx_inc[SW-1:0];
	assign scan_start = cmd.scan_find | cmd.scan_free | cmd.scan_next;

	always_comb begin
		if (mode_next_q) begin
			probe_ok = slot_act_q[ptr_s1] & slot_rdy_q[ptr_s1];
		end else if (mode_free_q) begin
			probe_ok = ~slot_act_q[ptr_s1];
		end else begin
			probe_ok = slot_act_q[ptr_s1] & (mbr_s1 == m_q);
		end
	end

	assign hit_s1    = vld_s1 & probe_ok;
	assign scan_done = busy_q & (hit_s1 | ((left_q == '0) & ~vld_s1));

	always_ff @(posedge clk) begin
		if (cmd.install) begin
			slot_mem[ins_idx] <= m_q;
		end
		mbr_s1 <= slot_mem[addr_q];
		ptr_s1 <= addr_q;
		if (scan_done && mode_next_q && hit_s1) begin
			nxt_mbr_q <= mbr_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			mode_free_q <= 1'b0;
			mode_next_q <= 1'b0;
			addr_q      <= '0;
			left_q      <= '0;
			vld_s1      <= 1'b0;
			slot_hit_q  <= 1'b0;
			slot_idx_q  <= '0;
			nxt_hit_q   <= 1'b0;
		end else if (scan_start) begin
			busy_q      <= 1'b1;
			vld_s1      <= 1'b0;
			mode_free_q <= cmd.scan_free;
			mode_next_q <= cmd.scan_next;
			// The search for a successor skips the starting slot itself.
			addr_q      <= cmd.scan_next ? next_start : '0;
			left_q      <= cmd.scan_next ? (used_q - CW'(1)) : used_q;
		end else if (scan_done) begin
			busy_q <= 1'b0;
			vld_s1 <= 1'b0;
			if (mode_next_q) begin
				nxt_hit_q <= hit_s1;
			end else begin
				slot_hit_q <= hit_s1;
				if (hit_s1) begin
					slot_idx_q <= ptr_s1;
				end
			end
		end else if (busy_q) begin
			vld_s1 <= (left_q != '0);
			if (left_q != '0) begin
				addr_q <= addr_wrap;
				left_q <= left_q - CW'(1);
			end
		end
	end

	// Token holder, hand-over total and per-event flags.
	logic              hold_vld_q;
	logic [MBR_W-1:0]  hold_id_q;
	logic [WORD_W-1:0] total_q;
	logic              wait_rule_q;
	logic              full_q;
	logic              passed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q  <= 1'b0;
			hold_id_q   <= '0;
			total_q     <= '0;
			wait_rule_q <= 1'b0;
			full_q      <= 1'b0;
			passed_q    <= 1'b0;
		end else begin
			if (cmd.take_self || (cmd.take_if_free && !hold_vld_q)) begin
				hold_vld_q <= 1'b1;
				hold_id_q  <= m_q;
			end else if (cmd.rel_tok) begin
				hold_vld_q <= 1'b0;
			end else if (cmd.hand_over) begin
				hold_id_q <= nxt_mbr_q;
			end
			if (cmd.count_pass) begin
				total_q <= total_q + 32'd1;
			end
			if (cmd.load) begin
				wait_rule_q <= 1'b0;
				full_q      <= 1'b0;
				passed_q    <= 1'b0;
			end else begin
				if (cmd.wait_rule) begin
					wait_rule_q <= 1'b1;
				end
				if (cmd.set_full) begin
					full_q <= 1'b1;
				end
				if (cmd.hand_over) begin
					passed_q <= 1'b1;
				end
			end
		end
	end

	// Result register.
	logic              out_valid_q;
	logic              res_vld_q;
	logic [MBR_W-1:0]  res_id_q;
	logic              res_wait_q;
	logic              res_full_q;
	logic              res_pass_q;
	logic [WORD_W-1:0] res_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_vld_q   <= hold_vld_q;
			res_id_q    <= hold_vld_q ? hold_id_q : '0;
			res_wait_q  <= wait_rule_q & hold_vld_q & (hold_id_q != m_q);
			res_full_q  <= full_q;
			res_pass_q  <= passed_q;
			res_count_q <= total_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign holder_valid = res_vld_q;
	assign holder_id    = res_id_q;
	assign must_wait    = res_wait_q;
	assign ring_full    = res_full_q;
	assign token_passed = res_pass_q;
	assign pass_count   = res_count_q;

	// Status towards the controller.
	always_comb begin
		sts             = '0;
		sts.ignore      = ~gate_q | (op_q > OP_BLOCK_END) | (m_wide >= MX'(MEMBER_IDS));
		sts.op          = op_q;
		sts.tick_below  = (tick_next < quantum_q);
		sts.scan_busy   = busy_q;
		sts.scan_done   = scan_done;
		sts.slot_hit    = slot_hit_q;
		sts.nxt_hit     = nxt_hit_q;
		sts.slots_avail = (used_q < CW'(RING_SLOTS));
		sts.is_holder   = hold_vld_q & (hold_id_q == m_q);
		sts.out_free    = ~out_valid_q | ~out_stall;
	end

endmodule

// File: rtl/core/round_robin_token_gate_top.sv
// Takes one event at a time and gives one result beat for each event.
// Events that search the ring take longer than an ignored event or a tick below the quantum,
// and longer still when a successor is sought, as the slot scanner probes one slot per cycle
// via the member memory. The result is registered after the last working cycle; a waiting
// beat holds the next event.
// Reset clears slots, tick counters, holder and pass count, disables the gate, quantum 65536.
// ----------------------------------------------------------------------------
// Round robin token gate: top level
// One run token shared by a ring of members, handed on in ring order.
// ----------------------------------------------------------------------------
module round_robin_token_gate_top import rrtg_pkg::*; #(
	parameter int RING_SLOTS = DEF_RING_SLOTS,
	parameter int MEMBER_IDS = DEF_MEMBER_IDS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OP_W-1:0]      op,
	input  logic [MBR_W-1:0]     member_id,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 holder_valid,
	output logic [MBR_W-1:0]     holder_id,
	output logic                 must_wait,
	output logic                 ring_full,
	output logic                 token_passed,
	output logic [WORD_W-1:0]    pass_count
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	rrtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rrtg_datapath #(
		.RING_SLOTS (RING_SLOTS),
		.MEMBER_IDS (MEMBER_IDS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.member_id    (member_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.holder_valid (holder_valid),
		.holder_id    (holder_id),
		.must_wait    (must_wait),
		.ring_full    (ring_full),
		.token_passed (token_passed),
		.pass_count   (pass_count),
		.cmd          (cmd),
		.sts          (sts)
	);

	// A new scan must never be started over one that is still running.
	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_find || cmd.scan_free || cmd.scan_next) |-> !sts.scan_busy)
		else $error("slot scan started while the scanner was busy");

	// A result is only loaded when the output register is free or being emptied.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an untaken beat");

	// A hand-over always leaves a holder behind.
	a_pass_holder: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_passed) |-> holder_valid)
		else $error("token passed but no holder reported");

	// A full ring leaves the caller ungated, so it neither waits nor passes.
	a_full_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ring_full) |-> (!must_wait && !token_passed))
		else $error("ring full reported together with wait or pass");

	// Waiting is only ever for an existing holder.
	a_wait_holder: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && must_wait) |-> holder_valid)
		else $error("caller told to wait with no holder");

endmodule

// File: verif/tb_round_robin_token_gate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round robin token gate: self-checking testbench
// Runs a short directed sequence and then phases of random ring events under
// several gate and quantum settings and idling patterns. Each accepted event
// is run through a local model of the ring. Each result beat is compared with
// the oldest predicted verdict.
// ----------------------------------------------------------------------------
module tb_round_robin_token_gate_top;
	import rrtg_pkg::*;

	localparam int RING_SLOTS     = DEF_RING_SLOTS;
	localparam int MEMBER_IDS     = DEF_MEMBER_IDS;
	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 6;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int END_SETTLE     = 80;
	localparam int PHASE_EVENTS   = 14;
	localparam int FILL_EVENTS    = 40;
	localparam int NUM_SETTINGS   = 8;

	localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

	typedef enum int {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [MBR_W-1:0] mbr;
	} gate_event_t;

	typedef struct packed {
		logic              holder_valid;
		logic [MBR_W-1:0]  holder_id;
		logic              must_wait;
		logic              ring_full;
		logic              token_passed;
		logic [WORD_W-1:0] pass_count;
	} gate_verdict_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      op        = '0;
	logic [MBR_W-1:0]     member_id = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 holder_valid;
	logic [MBR_W-1:0]     holder_id;
	logic                 must_wait;
	logic                 ring_full;
	logic                 token_passed;
	logic [WORD_W-1:0]    pass_count;

	round_robin_token_gate_top #(
		.RING_SLOTS(RING_SLOTS),
		.MEMBER_IDS(MEMBER_IDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.member_id(member_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.holder_valid(holder_valid),
		.holder_id(holder_id),
		.must_wait(must_wait),
		.ring_full(ring_full),
		.token_passed(token_passed),
		.pass_count(pass_count)
	);

	always #HALF_PERIOD clk = ~clk;

	// Local copy of the ring state and the configuration.
	logic [MBR_W-1:0]  ring_mbr [RING_SLOTS];
	bit                ring_act [RING_SLOTS];
	bit                ring_run [RING_SLOTS];
	int                ring_len = 0;
	bit                tok_held = 1'b0;
	logic [MBR_W-1:0]  tok_owner = '0;
	logic [WORD_W-1:0] tick_cnt [MEMBER_IDS];
	logic [WORD_W-1:0] handovers = '0;
	bit                gate_on = 1'b0;
	logic [WORD_W-1:0] quantum_val = QUANTUM_RST;

	gate_event_t   event_backlog[$];
	gate_verdict_t expected_verdicts[$];
	gate_event_t   drive_ev;
	gate_event_t   seen_ev;
	gate_verdict_t want;
	int            mismatch_count = 0;
	int            quiet_cycles = 0;
	int            src_idle_pct = 0;
	int            sink_stall_pct = 0;
	bit            in_fired = 1'b0;

	initial begin
		for (int i = 0; i < RING_SLOTS; i++) begin
			ring_mbr[i] = '0;
			ring_act[i] = 1'b0;
			ring_run[i] = 1'b0;
		end
		for (int i = 0; i < MEMBER_IDS; i++)
			tick_cnt[i] = '0;
	end

	function automatic int slot_of(logic [MBR_W-1:0] m);
		int idx;
		idx = -1;
		for (int i = 0; i < ring_len && i < RING_SLOTS; i++)
			if (idx < 0 && ring_act[i] && ring_mbr[i] == m)
				idx = i;
		return idx;
	endfunction

	// Next active, runnable slot after idx in ring order.
	function automatic int successor(int idx);
		int nx;
		int i;
		nx = -1;
		if (ring_len == 0 || idx < 0)
			return -1;
		for (int step = 1; step < ring_len; step++) begin
			i = (idx + step) % ring_len;
			if (nx < 0 && ring_act[i] && ring_run[i])
				nx = i;
		end
		return nx;
	endfunction

	function automatic bit release_token_by(logic [MBR_W-1:0] m, bit keep);
		int idx;
		int nx;
		idx = slot_of(m);
		if (idx >= 0)
			ring_run[idx] = keep;
		if (!tok_held || tok_owner != m)
			return 1'b0;
		nx = successor(idx);
		if (nx < 0) begin
			tok_held = 1'b0;
			return 1'b0;
		end
		tok_owner = ring_mbr[nx];
		handovers = handovers + 1;
		return 1'b1;
	endfunction

	function automatic gate_verdict_t predict_gate_event(gate_event_t ev);
		gate_verdict_t v;
		bit wait_rule;
		bit full;
		bit passed;
		int idx;
		int nx;
		logic [MBR_W-1:0] m;
		wait_rule = 1'b0;
		full = 1'b0;
		passed = 1'b0;
		m = ev.mbr;
		if (gate_on && ev.op <= OP_BLOCK_END && int'(m) < MEMBER_IDS) begin
			case (ev.op)
				OP_REGISTER: begin
					tick_cnt[m] = '0;
					idx = -1;
					for (int i = 0; i < ring_len && i < RING_SLOTS; i++)
						if (idx < 0 && !ring_act[i])
							idx = i;
					if (idx < 0 && ring_len >= RING_SLOTS) begin
						full = 1'b1;
					end else begin
						if (idx < 0) begin
							idx = ring_len;
							ring_len++;
						end
						ring_mbr[idx] = m;
						ring_act[idx] = 1'b1;
						ring_run[idx] = 1'b1;
						if (!tok_held) begin
							tok_held = 1'b1;
							tok_owner = m;
						end
						wait_rule = 1'b1;
					end
				end
				OP_UNREGISTER: begin
					idx = slot_of(m);
					if (idx >= 0) begin
						// Losing the holder hands the token on without counting a pass.
						if (tok_held && tok_owner == m) begin
							nx = successor(idx);
							if (nx >= 0) begin
								tok_owner = ring_mbr[nx];
								passed = 1'b1;
							end else begin
								tok_held = 1'b0;
							end
						end
						ring_act[idx] = 1'b0;
					end
				end
				OP_TICK: begin
					tick_cnt[m] = tick_cnt[m] + 1;
					if (tick_cnt[m] >= quantum_val) begin
						tick_cnt[m] = '0;
						if (release_token_by(m, 1'b1)) begin
							passed = 1'b1;
						end else begin
							tok_held = 1'b1;
							tok_owner = m;
						end
						wait_rule = 1'b1;
					end
				end
				OP_BLOCK_BEGIN: begin
					if (release_token_by(m, 1'b0))
						passed = 1'b1;
				end
				default: begin
					idx = slot_of(m);
					if (idx >= 0)
						ring_run[idx] = 1'b1;
					if (!tok_held) begin
						tok_held = 1'b1;
						tok_owner = m;
					end
					wait_rule = 1'b1;
				end
			endcase
		end
		v.holder_valid = tok_held;
		v.holder_id    = tok_held ? tok_owner : '0;
		v.must_wait    = wait_rule && tok_held && tok_owner != m;
		v.ring_full    = full;
		v.token_passed = passed;
		v.pass_count   = handovers;
		return v;
	endfunction

	task automatic report_fault(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] exp_val);
		if (got !== exp_val)
			report_fault($sformatf("%s is %0h, predicted %0h", name, got, exp_val));
	endtask

	// Source side: a beat is held until it has been taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fired)) begin
			if (event_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				drive_ev = event_backlog.pop_front();
				in_valid <= 1'b1;
				op <= drive_ev.op;
				member_id <= drive_ev.mbr;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_fired <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				seen_ev.op = op;
				seen_ev.mbr = member_id;
				expected_verdicts.push_back(predict_gate_event(seen_ev));
			end
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					report_fault("result beat with no event outstanding");
				end else begin
					want = expected_verdicts.pop_front();
					check_field("holder_valid", WORD_W'(holder_valid),
						WORD_W'(want.holder_valid));
					check_field("holder_id", WORD_W'(holder_id), WORD_W'(want.holder_id));
					check_field("must_wait", WORD_W'(must_wait), WORD_W'(want.must_wait));
					check_field("ring_full", WORD_W'(ring_full), WORD_W'(want.ring_full));
					check_field("token_passed", WORD_W'(token_passed),
						WORD_W'(want.token_passed));
					check_field("pass_count", pass_count, want.pass_count);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic push_event(input logic [OP_W-1:0] o, input logic [MBR_W-1:0] m);
		gate_event_t ev;
		ev.op = o;
		ev.mbr = m;
		event_backlog.push_back(ev);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_GATE_ENABLE)
			gate_on = val[0];
		else
			quantum_val = val;
	endtask

	task automatic wait_idle();
		while (event_backlog.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			IDLE_SOURCE: begin src_idle_pct = 73; sink_stall_pct = 0;  end
			IDLE_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 73; end
			default:     begin src_idle_pct = 14; sink_stall_pct = 14; end
		endcase
	endtask

	function automatic logic [MBR_W-1:0] pick_member();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return MBR_W'($urandom_range(5));
		else if (r < 90)
			return MBR_W'($urandom_range(MEMBER_IDS - 1));
		else
			return (r < 95) ? MBR_W'(0) : MBR_W'(MEMBER_IDS - 1);
	endfunction

	// Mostly events from a small pool of members, so that ticks, blocking and
	// hand-overs meet registered members; a few reserved codes as noise.
	task automatic add_random_events(input int count);
		int r;
		logic [OP_W-1:0] o;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 28)      o = OP_REGISTER;
			else if (r < 40) o = OP_UNREGISTER;
			else if (r < 72) o = OP_TICK;
			else if (r < 84) o = OP_BLOCK_BEGIN;
			else if (r < 96) o = OP_BLOCK_END;
			else             o = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
			push_event(o, pick_member());
		end
	endtask

	logic [WORD_W-1:0] set_quantum [NUM_SETTINGS] = '{
		32'd1, 32'd3, 32'hFFFF_FFFF, 32'd5, 32'd2, 32'd0, QUANTUM_RST, 32'd1
	};
	bit set_gate [NUM_SETTINGS] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The gate is off after reset, so these are ignored.
		push_event(OP_REGISTER, 5'd0);
		push_event(OP_TICK, 5'd0);
		push_event(OP_RSVD_FIRST, 5'd31);
		wait_idle();

		write_cfg(CFG_GATE_ENABLE, 32'd1);
		write_cfg(CFG_QUANTUM, 32'd2);
		push_event(OP_REGISTER, 5'd0);
		push_event(OP_REGISTER, 5'd31);
		push_event(OP_REGISTER, 5'd5);
		push_event(OP_REGISTER, 5'd5);
		push_event(OP_TICK, 5'd31);
		push_event(OP_TICK, 5'd31);
		push_event(OP_TICK, 5'd31);
		push_event(OP_TICK, 5'd31);
		push_event(OP_BLOCK_BEGIN, 5'd5);
		push_event(OP_BLOCK_END, 5'd5);
		push_event(OP_UNREGISTER, 5'd5);
		push_event(OP_UNREGISTER, 5'd0);
		push_event(OP_UNREGISTER, 5'd9);
		push_event(OP_BLOCK_BEGIN, 5'd9);
		push_event(OP_BLOCK_END, 5'd9);
		push_event(OP_BLOCK_BEGIN, 5'd31);
		push_event(OP_BLOCK_BEGIN, 5'd5);
		push_event(OP_BLOCK_END, 5'd31);
		push_event(OP_REGISTER, 5'd9);
		push_event(OP_RSVD_LAST, 5'd0);
		wait_idle();

		// With a quantum of zero every tick is at the quantum.
		write_cfg(CFG_QUANTUM, 32'd0);
		push_event(OP_TICK, 5'd9);
		push_event(OP_TICK, 5'd31);
		push_event(OP_TICK, 5'd17);
		wait_idle();

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			write_cfg(CFG_GATE_ENABLE, 32'(set_gate[s]));
			write_cfg(CFG_QUANTUM, set_quantum[s]);
			for (int mode = IDLE_NONE; mode <= IDLE_BOTH; mode++) begin
				set_idling(idle_mode_t'(mode));
				// One burst of registrations fills every slot and overflows the ring.
				if (s == 4 && mode == IDLE_NONE)
					for (int n = 0; n < FILL_EVENTS; n++)
						push_event(OP_REGISTER, MBR_W'($urandom_range(MEMBER_IDS - 1)));
				add_random_events(PHASE_EVENTS);
				wait_idle();
			end
		end

		repeat (END_SETTLE) @(posedge clk);
		if (expected_verdicts.size() != 0)
			report_fault("predicted verdicts left without a result beat");
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
